// File: sv/fcp_pkg.sv
// Shared types, constants and lookup functions for the framed command parser.
// No dependencies.
package fcp_pkg;

   localparam int ValueBitsDefault = 16;
   localparam int OutBits          = 16;
   localparam int KindCount        = 6;
   localparam int SlotCount        = 9;

   localparam logic [2:0] KindGains   = 3'd0;
   localparam logic [2:0] KindHeading = 3'd1;
   localparam logic [2:0] KindStop    = 3'd2;
   localparam logic [2:0] KindMove    = 3'd3;
   localparam logic [2:0] KindGripper = 3'd4;
   localparam logic [2:0] KindAlign   = 3'd5;

   localparam logic [7:0] CharP     = 8'h50;
   localparam logic [7:0] CharA     = 8'h41;
   localparam logic [7:0] CharS     = 8'h53;
   localparam logic [7:0] CharF     = 8'h46;
   localparam logic [7:0] CharB     = 8'h42;
   localparam logic [7:0] CharZ     = 8'h5A;
   localparam logic [7:0] CharBar   = 8'h7C;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharClose = 8'h3E;
   localparam logic [7:0] CharOpen  = 8'h3C;

   // Frame-end snapshot handed from the parser to the drain stage.
   typedef struct packed {
      logic                                load;
      logic [KindCount-1:0]                mask;
      logic [SlotCount-1:0][OutBits-1:0]   values;
   } snap_type;

   function automatic logic [1:0] field_count(input logic [2:0] kind);
      logic [1:0] n;
      case (kind)
         KindGains:   n = 2'd3;
         KindGripper: n = 2'd2;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] value_base(input logic [2:0] kind);
      logic [3:0] b;
      case (kind)
         KindGains:   b = 4'd0;
         KindHeading: b = 4'd3;
         KindStop:    b = 4'd4;
         KindMove:    b = 4'd5;
         KindGripper: b = 4'd6;
         KindAlign:   b = 4'd8;
         default:     b = 4'd0;
      endcase
      return b;
   endfunction

endpackage

// File: sv/fcp_parser.sv
// Byte parser: frame tracking, field accumulation and the pending command store.
// Depends on fcp_pkg.
module fcp_parser
   import fcp_pkg::*;
#(
   parameter int VALUE_BITS = ValueBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output snap_type   snap
);

   logic                  in_frame_ff, in_frame_in;
   logic                  busy_ff, busy_in;
   logic [2:0]            kind_ff, kind_in;
   logic [1:0]            idx_ff, idx_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] hold_ff [2];
   logic [VALUE_BITS-1:0] hold_in [2];
   logic [KindCount-1:0]  pend_valid_ff, pend_valid_in;
   logic [VALUE_BITS-1:0] pend_ff [SlotCount];
   logic [VALUE_BITS-1:0] pend_in [SlotCount];

   logic [VALUE_BITS-1:0] acc_next;
   logic                  letter;
   logic [2:0]            letter_kind;
   logic [2:0]            idx_plus;

   // value*10 + (byte - '0'), wrapping
   assign acc_next = VALUE_BITS'({acc_ff, 3'b000}) + VALUE_BITS'({acc_ff, 1'b0})
                     + VALUE_BITS'(rx_byte) - VALUE_BITS'(CharZero);

   assign idx_plus = {1'b0, idx_ff} + 3'd1;

   always_comb begin
      letter      = 1'b1;
      letter_kind = KindGains;
      case (rx_byte)
         CharP:   letter_kind = KindGains;
         CharA:   letter_kind = KindHeading;
         CharS:   letter_kind = KindStop;
         CharF:   letter_kind = KindMove;
         CharB:   letter_kind = KindGripper;
         CharZ:   letter_kind = KindAlign;
         default: letter = 1'b0;
      endcase
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      busy_in       = busy_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      hold_in       = hold_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      snap.load     = 1'b0;
      snap.mask     = pend_valid_ff;
      for (int i = 0; i < SlotCount; i++) begin
         snap.values[i] = OutBits'(pend_ff[i]);
      end

      if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == CharOpen) begin
               in_frame_in   = 1'b1;
               busy_in       = 1'b0;
               idx_in        = '0;
               acc_in        = '0;
               pend_valid_in = '0;
            end
         end else if (rx_byte == CharClose) begin
            snap.load     = |pend_valid_ff;
            pend_valid_in = '0;
            in_frame_in   = 1'b0;
            busy_in       = 1'b0;
            idx_in        = '0;
            acc_in        = '0;
         end else if (!busy_ff) begin
            if (letter) begin
               busy_in = 1'b1;
               kind_in = letter_kind;
               idx_in  = '0;
               acc_in  = '0;
            end
         end else if (rx_byte == CharBar) begin
            if (idx_plus < {1'b0, field_count(kind_ff)}) begin
               hold_in[idx_ff[0]] = acc_ff;
               idx_in             = idx_plus[1:0];
               acc_in             = '0;
            end else begin
               case (kind_ff)
                  KindGains: begin
                     pend_in[0] = hold_ff[0];
                     pend_in[1] = hold_ff[1];
                     pend_in[2] = acc_ff;
                  end
                  KindGripper: begin
                     pend_in[6] = hold_ff[0];
                     pend_in[7] = acc_ff;
                  end
                  KindHeading: pend_in[3] = acc_ff;
                  KindStop:    pend_in[4] = acc_ff;
                  KindMove:    pend_in[5] = acc_ff;
                  KindAlign:   pend_in[8] = acc_ff;
                  default: ;
               endcase
               pend_valid_in[kind_ff] = 1'b1;
               busy_in = 1'b0;
               idx_in  = '0;
               acc_in  = '0;
            end
         end else begin
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         idx_ff        <= '0;
         acc_ff        <= '0;
         pend_valid_ff <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         busy_ff       <= busy_in;
         idx_ff        <= idx_in;
         acc_ff        <= acc_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      hold_ff <= hold_in;
      pend_ff <= pend_in;
   end

endmodule

// File: sv/fcp_drain.sv
// Frame-end drain: holds the snapshot and emits one update per cycle into
// the response register while it is empty or being taken. Depends on fcp_pkg.
module fcp_drain
   import fcp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  snap_type                  snap,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_update_kind,
   output logic signed [OutBits-1:0] rsp_value_a,
   output logic signed [OutBits-1:0] rsp_value_b,
   output logic signed [OutBits-1:0] rsp_value_c,
   output logic                      rsp_last_update
);

   logic [KindCount-1:0]              mask_ff, mask_in;
   logic [SlotCount-1:0][OutBits-1:0] vals_ff, vals_in;
   logic                              valid_ff, valid_in;
   logic [2:0]                        kind_ff, kind_in;
   logic [OutBits-1:0]                a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                              last_ff, last_in;

   logic [2:0]           pick;
   logic [KindCount-1:0] rest;
   logic                 fire;

   // lowest pending kind goes first
   always_comb begin
      pick = KindGains;
      for (int k = KindCount - 1; k >= 0; k--) begin
         if (mask_ff[k]) pick = 3'(k);
      end
      rest       = mask_ff;
      rest[pick] = 1'b0;
   end

   assign busy = |mask_ff;
   assign fire = busy && (!valid_ff || rsp_ready);

   always_comb begin
      mask_in  = mask_ff;
      vals_in  = vals_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      last_in  = last_ff;
      if (snap.load) begin
         mask_in = snap.mask;
         vals_in = snap.values;
      end else if (fire) begin
         mask_in  = rest;
         valid_in = 1'b1;
         kind_in  = pick;
         last_in  = (rest == '0);
         a_in     = vals_ff[value_base(pick)];
         b_in     = '0;
         c_in     = '0;
         case (pick)
            KindGains: begin
               b_in = vals_ff[1];
               c_in = vals_ff[2];
            end
            KindGripper: b_in = vals_ff[7];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_update_kind = kind_ff;
   assign rsp_value_a     = $signed(a_ff);
   assign rsp_value_b     = $signed(b_ff);
   assign rsp_value_c     = $signed(c_ff);
   assign rsp_last_update = last_ff;

endmodule

// File: sv/framed_command_parser.sv
// Framed command parser, top level: parser stage plus frame-end drain stage.
// Depends on fcp_pkg, fcp_parser, fcp_drain.
//
// Request channel (req_valid/req_ready/req_rx_byte) takes one received byte
// per request. Bytes count between '<' and '>'; commands P, A, S, F, B, Z
// with '|'-terminated decimal fields are stored as pending, newest wins.
// Bytes that produce nothing keep the channel at one request per cycle.
// At '>' the pending set is copied into the drain stage. The first update
// then moves into the response register and appears on rsp_*, then one
// update per cycle while rsp_ready is high, in order gains, heading, stop,
// move, gripper, align, with rsp_last_update on the final one. req_ready
// stays low only while the drain stage still holds updates not yet moved
// into the response register; it is high while the last update waits to
// be taken.
// A receiver stall holds the response register and, behind it, the drain.
// Reset clears the frame state, the pending set and the response valid.
module framed_command_parser
   import fcp_pkg::*;
#(
   parameter int VALUE_BITS = ValueBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_update_kind,
   output logic signed [OutBits-1:0] rsp_value_a,
   output logic signed [OutBits-1:0] rsp_value_b,
   output logic signed [OutBits-1:0] rsp_value_c,
   output logic                      rsp_last_update
);

   snap_type snap;
   logic     drain_busy;

   assign req_ready = !drain_busy;

   fcp_parser #(
      .VALUE_BITS(VALUE_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .rx_byte (req_rx_byte),
      .snap    (snap)
   );

   fcp_drain u_drain (
      .clock           (clock),
      .reset           (reset),
      .snap            (snap),
      .busy            (drain_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_update_kind (rsp_update_kind),
      .rsp_value_a     (rsp_value_a),
      .rsp_value_b     (rsp_value_b),
      .rsp_value_c     (rsp_value_c),
      .rsp_last_update (rsp_last_update)
   );

endmodule

// File: sv/fcp_checker.sv
// Port-level checks for framed_command_parser, bound to the top level.
// Depends on fcp_pkg.
module fcp_checker
   import fcp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [2:0]                rsp_update_kind,
   input logic signed [OutBits-1:0] rsp_value_a,
   input logic                      rsp_last_update
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_update_kind)
         && $stable(rsp_value_a) && $stable(rsp_last_update))
      else $error("response changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_update_kind <= KindAlign)
      else $error("update kind out of range");

   // within one frame the updates follow back to back in rising kind order
   a_kind_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_update |=>
         rsp_valid && (rsp_update_kind > $past(rsp_update_kind)))
      else $error("frame updates out of order or gapped");

   // more updates of this frame still queued behind the register
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_update |-> !req_ready)
      else $error("request taken while a frame is still draining");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind framed_command_parser fcp_checker u_fcp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_update_kind (rsp_update_kind),
   .rsp_value_a     (rsp_value_a),
   .rsp_last_update (rsp_last_update)
);

// File: verif/framed_command_parser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for framed_command_parser: a queue-fed byte driver,
// a response monitor and a behavioural frame parser that predicts each update.
// Depends on fcp_pkg and the framed_command_parser RTL.
module framed_command_parser_test
   import fcp_pkg::*;
;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic        last;
   } update_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_update_kind;
   logic signed [15:0] rsp_value_a;
   logic signed [15:0] rsp_value_b;
   logic signed [15:0] rsp_value_c;
   logic rsp_last_update;

   // bit 8 set: hold this byte back until every predicted update has come out
   logic [8:0]  pending_bytes [$];
   update_rec_type expected_updates [$];
   update_rec_type head;

   int bytes_taken = 0;
   int frames_closed = 0;
   int updates_seen = 0;
   int mismatches = 0;
   int frame_no;

   // shadow of the parser state
   bit          framing = 1'b0;
   bit          cmd_open = 1'b0;
   logic [2:0]  cmd_kind = KindGains;
   int          field_no = 0;
   logic [15:0] accum = '0;
   logic [15:0] held [2];
   logic [5:0]  have = '0;
   logic [15:0] slot_val [9];

   wire steady = (bytes_taken >= 150) && (bytes_taken < 300);

   framed_command_parser DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_update_kind(rsp_update_kind),
      .rsp_value_a(rsp_value_a),
      .rsp_value_b(rsp_value_b),
      .rsp_value_c(rsp_value_c),
      .rsp_last_update(rsp_last_update)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int fields_of(input logic [2:0] kind);
      if (kind == KindGains) return 3;
      if (kind == KindGripper) return 2;
      return 1;
   endfunction

   function automatic int slot_of(input logic [2:0] kind);
      int s;
      case (kind)
         KindGains:   s = 0;
         KindHeading: s = 3;
         KindStop:    s = 4;
         KindMove:    s = 5;
         KindGripper: s = 6;
         default:     s = 8;
      endcase
      return s;
   endfunction

   // returns {is_command, kind}
   function automatic logic [3:0] letter_kind(input logic [7:0] b);
      logic [3:0] r;
      case (b)
         CharP:   r = {1'b1, KindGains};
         CharA:   r = {1'b1, KindHeading};
         CharS:   r = {1'b1, KindStop};
         CharF:   r = {1'b1, KindMove};
         CharB:   r = {1'b1, KindGripper};
         CharZ:   r = {1'b1, KindAlign};
         default: r = 4'b0000;
      endcase
      return r;
   endfunction

   task automatic drop_command();
      cmd_open = 1'b0;
      field_no = 0;
      accum = '0;
      held[0] = '0;
      held[1] = '0;
   endtask

   task automatic close_field();
      int need;
      int base;
      need = fields_of(cmd_kind);
      base = slot_of(cmd_kind);
      if (field_no + 1 < need) begin
         held[field_no] = accum;
         field_no++;
         accum = '0;
      end else begin
         for (int f = 0; f + 1 < need; f++)
            slot_val[base + f] = held[f];
         slot_val[base + need - 1] = accum;
         have[cmd_kind] = 1'b1;
         drop_command();
      end
   endtask

   // advance the shadow parser by one byte and queue any updates it emits
   task automatic parse_byte(input logic [7:0] b);
      update_rec_type u;
      logic [3:0] lk;
      int total;
      int emitted;
      int base;
      int need;
      if (!framing) begin
         if (b == CharOpen) begin
            framing = 1'b1;
            drop_command();
            have = '0;
         end
      end else if (b == CharClose) begin
         total = $countones(have);
         emitted = 0;
         for (int k = 0; k < KindCount; k++) begin
            if (have[k]) begin
               base = slot_of(k[2:0]);
               need = fields_of(k[2:0]);
               u.kind = k[2:0];
               u.a = slot_val[base];
               u.b = (need >= 2) ? slot_val[base + 1] : '0;
               u.c = (need >= 3) ? slot_val[base + 2] : '0;
               u.last = (emitted == total - 1);
               expected_updates.push_back(u);
               emitted++;
            end
         end
         have = '0;
         framing = 1'b0;
         drop_command();
         frames_closed++;
      end else if (!cmd_open) begin
         lk = letter_kind(b);
         if (lk[3]) begin
            drop_command();
            cmd_open = 1'b1;
            cmd_kind = lk[2:0];
         end
      end else if (b == CharBar) begin
         close_field();
      end else begin
         accum = accum * 16'd10 + {8'd0, b} - 16'd48;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_bytes[0][8] && expected_updates.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 33) begin
               req_valid <= 1'b0;
            end else begin
               req_rx_byte <= pending_bytes[0][7:0];
               req_valid <= 1'b1;
               void'(pending_bytes.pop_front());
            end
         end
      end
   end

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $display("%0t ns: unexpected update, expected none, got kind %0d a %h b %h c %h",
                        $time, rsp_update_kind, rsp_value_a, rsp_value_b, rsp_value_c);
               mismatches++;
            end else begin
               head = expected_updates.pop_front();
               check_field("update_kind", 16'(head.kind), 16'(rsp_update_kind));
               check_field("value_a", head.a, rsp_value_a);
               check_field("value_b", head.b, rsp_value_b);
               check_field("value_c", head.c, rsp_value_c);
               check_field("last_update", 16'(head.last), 16'(rsp_last_update));
               updates_seen++;
            end
         end
         rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
      end
   end

   task automatic queue_byte(input logic [7:0] b, input bit hold);
      pending_bytes.push_back({hold, b});
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], 1'b0);
   endtask

   // one field: decimal text mostly, sometimes arbitrary bytes or a sign
   task automatic queue_field(input bit terminate);
      int v;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 9);
            1: v = $urandom_range(0, 999);
            2: v = $urandom_range(0, 32767);
            default: v = $urandom_range(0, 999999);
         endcase
         if ($urandom_range(0, 9) == 0) v = -v;
         queue_text($sformatf("%0d", v));
      end
      if (terminate) queue_byte(CharBar, 1'b0);
   endtask

   task automatic queue_command(input bit complete);
      logic [7:0] letter;
      logic [3:0] lk;
      int need;
      case ($urandom_range(0, 5))
         0: letter = CharP;
         1: letter = CharA;
         2: letter = CharS;
         3: letter = CharF;
         4: letter = CharB;
         default: letter = CharZ;
      endcase
      lk = letter_kind(letter);
      need = fields_of(lk[2:0]);
      queue_byte(letter, 1'b0);
      if (complete) begin
         repeat (need) queue_field(1'b1);
      end else begin
         repeat ($urandom_range(0, need - 1)) queue_field(1'b1);
         if ($urandom_range(0, 1)) queue_field(1'b0);
      end
   endtask

   task automatic queue_frame(input bit hold);
      queue_byte(CharOpen, hold);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 4) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         queue_command(1'b1);
      end
      if ($urandom_range(0, 5) == 0) queue_command(1'b0);
      queue_byte(CharClose, 1'b0);
   endtask

   initial begin
      for (int i = 0; i < 9; i++) slot_val[i] = '0;
      held[0] = '0;
      held[1] = '0;

      // stray bytes and a stray close outside a frame, then an empty frame
      queue_text("x><>");
      // every command once, an empty field among them
      queue_text("<P1|2|3|A9|S|F0|B4|5|Z7|>");
      // a repeated '<' inside a frame, an overwritten heading, an unfinished align
      queue_text("<<A1|A2|Z>");

      frame_no = 0;
      while (pending_bytes.size() < 470) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         queue_frame(frame_no == 8 || frame_no == 20);
         frame_no++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Fed %0d bytes through %0d closed frames; %0d updates compared.",
               bytes_taken, frames_closed, updates_seen);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Timed out with %0d updates still outstanding", expected_updates.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
sv/fcp_pkg.sv
sv/fcp_parser.sv
sv/fcp_drain.sv
sv/framed_command_parser.sv
sv/fcp_checker.sv
verif/framed_command_parser_test.sv
